/* hw/rtl/dtt_pkg.sv */
// ----------------------------------------------------------------------------
// dtt_pkg
// Shared types and constants of the deadline timeout tracker: op codes,
// controller states and the command, status and result groups.
// ----------------------------------------------------------------------------
`default_nettype none

package dtt_pkg;

  localparam int unsigned DEF_PENDING_DEPTH = 16;
  localparam int unsigned DEF_EXPIRED_DEPTH = 16;

  localparam int unsigned DESC_W  = 16;
  localparam int unsigned TMO_W   = 16;
  localparam int unsigned TIME_W  = 32;
  localparam int unsigned SECS_W  = 16;
  localparam int unsigned OP_W    = 2;
  localparam int unsigned IN_W    = 64;
  localparam int unsigned OUT_W   = 24;

  localparam logic [OP_W-1:0] OP_ADD    = 2'd0;
  localparam logic [OP_W-1:0] OP_EXPIRE = 2'd1;
  localparam logic [OP_W-1:0] OP_CHECK  = 2'd2;

  localparam logic [SECS_W-1:0] MIN_COUNTDOWN = 16'd1;
  localparam logic [SECS_W-1:0] MAX_COUNTDOWN = 16'hFFFF;

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_P_RD   = 8'b0000_0010,
    S_P_SCAN = 8'b0000_0100,
    S_X_RD   = 8'b0000_1000,
    S_X_SCAN = 8'b0001_0000,
    S_X_END  = 8'b0010_0000,
    S_P_WR   = 8'b0100_0000,
    S_DONE   = 8'b1000_0000
  } state_e;

  typedef struct packed {
    logic [DESC_W-1:0] descriptor;
    logic [TMO_W-1:0]  timeout_seconds;
    logic [TIME_W-1:0] now_seconds;
  } item_t;

  typedef struct packed {
    logic capture;
    logic p_rd;
    logic p_inc;
    logic p_eval;
    logic p_write;
    logic x_clr;
    logic x_rd;
    logic x_inc;
    logic x_eval;
    logic x_end;
  } cmd_t;

  typedef struct packed {
    logic p_last;
    logic p_hit;
    logic x_last;
    logic x_match;
  } sts_t;

  typedef struct packed {
    logic              expired_lost;
    logic              pending_full;
    logic              timed_out;
    logic [SECS_W-1:0] alarm_seconds;
    logic              alarm_load;
  } res_t;

endpackage

`default_nettype wire

/* hw/rtl/deadline_timeout_tracker.sv */
// ----------------------------------------------------------------------------
// deadline_timeout_tracker
// Tracks call deadlines: add pending calls, move overdue calls to a timed-out
// set on alarm expiry with alarm reload, and check/remove timed-out calls.
//
//   channel   dir  beat contents
//   s_axis    in   tuser: op[1:0]; tdata: descriptor, timeout_seconds, now_seconds
//   m_axis    out  tdata: alarm_load, alarm_seconds, timed_out, pending_full,
//                  expired_lost
//
// Add walks the pending table and then writes; check walks the timed-out set;
// expire walks the pending table and the set once per overdue call; zero-timeout
// add and unused op skip the walks. Each table walk reads one memory entry a cycle.
// Reset clears all valid bits at once; no clearing pass.
// A stalled output holds its beat; the next input beat is taken meanwhile,
// and its result waits until the output register frees.
// ----------------------------------------------------------------------------
`default_nettype none

module deadline_timeout_tracker #(
  parameter int unsigned PENDING_DEPTH = dtt_pkg::DEF_PENDING_DEPTH,
  parameter int unsigned EXPIRED_DEPTH = dtt_pkg::DEF_EXPIRED_DEPTH
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          s_axis_tvalid_i,
  output logic                         s_axis_tready_o,
  // [15:0] descriptor, [31:16] timeout_seconds, [63:32] now_seconds
  input  wire [dtt_pkg::IN_W-1:0]      s_axis_tdata_i,
  // [1:0] op
  input  wire [dtt_pkg::OP_W-1:0]      s_axis_tuser_i,
  output logic                         m_axis_tvalid_o,
  input  wire                          m_axis_tready_i,
  // [0] alarm_load, [16:1] alarm_seconds, [17] timed_out, [18] pending_full,
  // [19] expired_lost, [23:20] zero
  output logic [dtt_pkg::OUT_W-1:0]    m_axis_tdata_o
);

  dtt_pkg::item_t item;
  dtt_pkg::cmd_t  cmd;
  dtt_pkg::sts_t  sts;
  dtt_pkg::res_t  res;
  logic           out_free;
  logic           out_load;
  logic           m_valid_q;
  logic [dtt_pkg::OUT_W-1:0] m_data_q;

  assign item.descriptor      = s_axis_tdata_i[15:0];
  assign item.timeout_seconds = s_axis_tdata_i[31:16];
  assign item.now_seconds     = s_axis_tdata_i[63:32];

  assign out_free = !m_valid_q || m_axis_tready_i;

  dtt_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (s_axis_tvalid_i),
    .in_op_i       (s_axis_tuser_i),
    .in_tmo_zero_i (item.timeout_seconds == '0),
    .in_ready_o    (s_axis_tready_o),
    .out_free_i    (out_free),
    .out_load_o    (out_load),
    .sts_i         (sts),
    .cmd_o         (cmd)
  );

  dtt_datapath #(
    .PENDING_DEPTH (PENDING_DEPTH),
    .EXPIRED_DEPTH (EXPIRED_DEPTH)
  ) u_datapath (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .item_i (item),
    .op_i   (s_axis_tuser_i),
    .cmd_i  (cmd),
    .sts_o  (sts),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (out_load) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      m_data_q <= {{(dtt_pkg::OUT_W - $bits(dtt_pkg::res_t)){1'b0}}, res};
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;

  // A waiting beat is never overwritten.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> (!m_valid_q || m_axis_tready_i))
    else $error("deadline_timeout_tracker: output beat overwritten");

endmodule

`default_nettype wire

/* hw/rtl/dtt_ctrl.sv */
// ----------------------------------------------------------------------------
// dtt_ctrl
// Sequencer of the tracker: walks the pending table and the timed-out set one
// entry a cycle and issues commands to the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

module dtt_ctrl (
  input  wire                       clk_i,
  input  wire                       rst_ni,
  input  wire                       in_valid_i,
  input  wire [dtt_pkg::OP_W-1:0]   in_op_i,
  input  wire                       in_tmo_zero_i,
  output logic                      in_ready_o,
  input  wire                       out_free_i,
  output logic                      out_load_o,
  input  wire dtt_pkg::sts_t        sts_i,
  output dtt_pkg::cmd_t             cmd_o
);

  dtt_pkg::state_e               state_q, state_d;
  logic [dtt_pkg::OP_W-1:0]      op_q, op_d;

  always_comb begin
    state_d    = state_q;
    op_d       = op_q;
    cmd_o      = '0;
    out_load_o = 1'b0;
    in_ready_o = 1'b0;
    case (state_q)
      dtt_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          op_d          = in_op_i;
          case (in_op_i)
            dtt_pkg::OP_ADD:    state_d = in_tmo_zero_i ? dtt_pkg::S_DONE : dtt_pkg::S_P_RD;
            dtt_pkg::OP_EXPIRE: state_d = dtt_pkg::S_P_RD;
            dtt_pkg::OP_CHECK:  state_d = dtt_pkg::S_X_RD;
            default:            state_d = dtt_pkg::S_DONE;
          endcase
        end
      end
      dtt_pkg::S_P_RD: begin
        cmd_o.p_rd = 1'b1;
        state_d    = dtt_pkg::S_P_SCAN;
      end
      dtt_pkg::S_P_SCAN: begin
        cmd_o.p_eval = 1'b1;
        if (op_q == dtt_pkg::OP_EXPIRE && sts_i.p_hit) begin
          cmd_o.x_clr = 1'b1;
          state_d     = dtt_pkg::S_X_RD;
        end else if (sts_i.p_last) begin
          state_d = (op_q == dtt_pkg::OP_ADD) ? dtt_pkg::S_P_WR : dtt_pkg::S_DONE;
        end else begin
          cmd_o.p_inc = 1'b1;
          cmd_o.p_rd  = 1'b1;
        end
      end
      dtt_pkg::S_X_RD: begin
        cmd_o.x_rd = 1'b1;
        state_d    = dtt_pkg::S_X_SCAN;
      end
      dtt_pkg::S_X_SCAN: begin
        cmd_o.x_eval = 1'b1;
        if (sts_i.x_match || sts_i.x_last) begin
          state_d = dtt_pkg::S_X_END;
        end else begin
          cmd_o.x_inc = 1'b1;
          cmd_o.x_rd  = 1'b1;
        end
      end
      dtt_pkg::S_X_END: begin
        cmd_o.x_end = 1'b1;
        if (op_q == dtt_pkg::OP_CHECK || sts_i.p_last) begin
          state_d = dtt_pkg::S_DONE;
        end else begin
          cmd_o.p_inc = 1'b1;
          state_d     = dtt_pkg::S_P_RD;
        end
      end
      dtt_pkg::S_P_WR: begin
        cmd_o.p_write = 1'b1;
        state_d       = dtt_pkg::S_DONE;
      end
      dtt_pkg::S_DONE: begin
        if (out_free_i) begin
          out_load_o = 1'b1;
          state_d    = dtt_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = dtt_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dtt_pkg::S_IDLE;
      op_q    <= dtt_pkg::OP_ADD;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
    end
  end

  // A result is only presented once per accepted item.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load_o |=> !out_load_o)
    else $error("dtt_ctrl: result loaded twice");

  // Never accept while an item is in flight.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("dtt_ctrl: accepted two items back to back");

  // Expired set walk always ends through its closing step.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.x_eval && (sts_i.x_match || sts_i.x_last)) |=> cmd_o.x_end)
    else $error("dtt_ctrl: set walk did not close");

endmodule

`default_nettype wire

/* hw/rtl/dtt_datapath.sv */
// ----------------------------------------------------------------------------
// dtt_datapath
// Pending table and timed-out set with their valid bits, walk counters,
// comparators, scan trackers and the alarm countdown.
// ----------------------------------------------------------------------------
`default_nettype none

module dtt_datapath #(
  parameter int unsigned PENDING_DEPTH = dtt_pkg::DEF_PENDING_DEPTH,
  parameter int unsigned EXPIRED_DEPTH = dtt_pkg::DEF_EXPIRED_DEPTH
) (
  input  wire                         clk_i,
  input  wire                         rst_ni,
  input  wire dtt_pkg::item_t         item_i,
  input  wire [dtt_pkg::OP_W-1:0]     op_i,
  input  wire dtt_pkg::cmd_t          cmd_i,
  output dtt_pkg::sts_t               sts_o,
  output dtt_pkg::res_t               res_o
);

  localparam int unsigned PW = $clog2(PENDING_DEPTH);
  localparam int unsigned XW = $clog2(EXPIRED_DEPTH);
  localparam logic [PW-1:0] P_LAST = PW'(PENDING_DEPTH - 1);
  localparam logic [XW-1:0] X_LAST = XW'(EXPIRED_DEPTH - 1);

  localparam int unsigned DW = dtt_pkg::DESC_W;
  localparam int unsigned TW = dtt_pkg::TIME_W;
  localparam int unsigned SW = dtt_pkg::SECS_W;

  logic [DW-1:0] pend_desc_mem [PENDING_DEPTH];
  logic [TW-1:0] pend_dl_mem   [PENDING_DEPTH];
  logic [DW-1:0] exp_desc_mem  [EXPIRED_DEPTH];

  logic [PENDING_DEPTH-1:0] pend_valid_q;
  logic [EXPIRED_DEPTH-1:0] exp_valid_q;

  logic [DW-1:0]          pend_desc_rd_q;
  logic [TW-1:0]          pend_dl_rd_q;
  logic [DW-1:0]          exp_desc_rd_q;

  logic [dtt_pkg::OP_W-1:0] op_q;
  logic                   tmo_zero_q;
  logic [TW-1:0]          now_q;
  logic [TW-1:0]          dl_new_q;
  logic [DW-1:0]          key_q;
  logic [PW-1:0]          pidx_q;
  logic [XW-1:0]          xidx_q;
  logic                   earliest_q;
  logic                   pfree_found_q;
  logic [PW-1:0]          pfree_idx_q;
  logic                   any_q;
  logic [TW-1:0]          best_q;
  logic                   xfree_found_q;
  logic [XW-1:0]          xfree_idx_q;
  logic                   matched_q;
  logic                   lost_q;
  logic                   tout_q;

  logic [TW:0]            dl_sum;
  logic [TW-1:0]          dl_sat;
  logic                   p_last, x_last;
  logic [PW-1:0]          p_next, p_raddr;
  logic [XW-1:0]          x_next, x_raddr;
  logic                   p_vld, p_hit, x_vld, x_match;
  logic                   is_expire, is_check, add_live;
  logic                   x_store;
  logic [TW-1:0]          cd_src, cd_diff;
  logic [SW-1:0]          countdown;

  assign dl_sum = {1'b0, item_i.now_seconds} + {{(TW + 1 - dtt_pkg::TMO_W){1'b0}},
                                                item_i.timeout_seconds};
  assign dl_sat = dl_sum[TW] ? {TW{1'b1}} : dl_sum[TW-1:0];

  assign p_last  = (pidx_q == P_LAST);
  assign x_last  = (xidx_q == X_LAST);
  assign p_next  = p_last ? '0 : pidx_q + 1'b1;
  assign x_next  = x_last ? '0 : xidx_q + 1'b1;
  assign p_raddr = cmd_i.p_inc ? p_next : pidx_q;
  assign x_raddr = cmd_i.x_inc ? x_next : xidx_q;

  assign is_expire = (op_q == dtt_pkg::OP_EXPIRE);
  assign is_check  = (op_q == dtt_pkg::OP_CHECK);
  assign add_live  = (op_q == dtt_pkg::OP_ADD) && !tmo_zero_q;

  assign p_vld   = pend_valid_q[pidx_q];
  assign p_hit   = p_vld && (pend_dl_rd_q < now_q);
  assign x_vld   = exp_valid_q[xidx_q];
  assign x_match = x_vld && (exp_desc_rd_q == key_q);
  assign x_store = cmd_i.x_end && is_expire && !matched_q && xfree_found_q;

  assign sts_o.p_last  = p_last;
  assign sts_o.p_hit   = p_hit;
  assign sts_o.x_last  = x_last;
  assign sts_o.x_match = x_match;

  // Memories: one write port, one registered read port each.
  always_ff @(posedge clk_i) begin
    if (cmd_i.p_write && pfree_found_q) begin
      pend_desc_mem[pfree_idx_q] <= key_q;
      pend_dl_mem[pfree_idx_q]   <= dl_new_q;
    end
    if (cmd_i.p_rd) begin
      pend_desc_rd_q <= pend_desc_mem[p_raddr];
      pend_dl_rd_q   <= pend_dl_mem[p_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (x_store) begin
      exp_desc_mem[xfree_idx_q] <= key_q;
    end
    if (cmd_i.x_rd) begin
      exp_desc_rd_q <= exp_desc_mem[x_raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_valid_q <= '0;
      exp_valid_q  <= '0;
    end else begin
      if (cmd_i.p_write && pfree_found_q) begin
        pend_valid_q[pfree_idx_q] <= 1'b1;
      end
      if (cmd_i.p_eval && is_expire && p_hit) begin
        pend_valid_q[pidx_q] <= 1'b0;
      end
      if (x_store) begin
        exp_valid_q[xfree_idx_q] <= 1'b1;
      end
      if (cmd_i.x_eval && x_match && is_check) begin
        exp_valid_q[xidx_q] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q       <= op_i;
      tmo_zero_q <= (item_i.timeout_seconds == '0);
      now_q      <= item_i.now_seconds;
      dl_new_q   <= dl_sat;
      key_q      <= item_i.descriptor;
    end else if (cmd_i.p_eval && is_expire && p_hit) begin
      key_q <= pend_desc_rd_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pidx_q        <= '0;
      xidx_q        <= '0;
      earliest_q    <= 1'b0;
      pfree_found_q <= 1'b0;
      pfree_idx_q   <= '0;
      any_q         <= 1'b0;
      best_q        <= '0;
      xfree_found_q <= 1'b0;
      xfree_idx_q   <= '0;
      matched_q     <= 1'b0;
      lost_q        <= 1'b0;
      tout_q        <= 1'b0;
    end else if (cmd_i.capture) begin
      pidx_q        <= '0;
      xidx_q        <= '0;
      earliest_q    <= 1'b1;
      pfree_found_q <= 1'b0;
      any_q         <= 1'b0;
      xfree_found_q <= 1'b0;
      matched_q     <= 1'b0;
      lost_q        <= 1'b0;
      tout_q        <= 1'b0;
    end else begin
      if (cmd_i.p_inc) begin
        pidx_q <= p_next;
      end
      if (cmd_i.p_eval) begin
        if (is_expire) begin
          if (!p_hit && p_vld && (!any_q || pend_dl_rd_q < best_q)) begin
            best_q <= pend_dl_rd_q;
            any_q  <= 1'b1;
          end
        end else begin
          if (p_vld && pend_dl_rd_q <= dl_new_q) begin
            earliest_q <= 1'b0;
          end
          if (!p_vld && !pfree_found_q) begin
            pfree_found_q <= 1'b1;
            pfree_idx_q   <= pidx_q;
          end
        end
      end
      if (cmd_i.x_clr) begin
        xidx_q        <= '0;
        xfree_found_q <= 1'b0;
        matched_q     <= 1'b0;
      end else begin
        if (cmd_i.x_inc) begin
          xidx_q <= x_next;
        end
        if (cmd_i.x_eval) begin
          if (x_match) begin
            matched_q <= 1'b1;
            if (is_check) begin
              tout_q <= 1'b1;
            end
          end else if (!x_vld && !xfree_found_q) begin
            xfree_found_q <= 1'b1;
            xfree_idx_q   <= xidx_q;
          end
        end
        if (cmd_i.x_end && is_expire && !matched_q && !xfree_found_q) begin
          lost_q <= 1'b1;
        end
      end
    end
  end

  // Countdown: max(deadline - now, 1), saturated to the alarm width.
  assign cd_src  = is_expire ? best_q : dl_new_q;
  assign cd_diff = cd_src - now_q;

  always_comb begin
    if (cd_src <= now_q) begin
      countdown = dtt_pkg::MIN_COUNTDOWN;
    end else if (cd_diff > {{(TW - SW){1'b0}}, dtt_pkg::MAX_COUNTDOWN}) begin
      countdown = dtt_pkg::MAX_COUNTDOWN;
    end else begin
      countdown = cd_diff[SW-1:0];
    end
  end

  always_comb begin
    res_o              = '0;
    res_o.timed_out    = is_check && tout_q;
    res_o.expired_lost = is_expire && lost_q;
    if (add_live) begin
      res_o.pending_full = !pfree_found_q;
      if (pfree_found_q && earliest_q) begin
        res_o.alarm_load    = 1'b1;
        res_o.alarm_seconds = countdown;
      end
    end else if (is_expire) begin
      res_o.alarm_load    = 1'b1;
      res_o.alarm_seconds = any_q ? countdown : '0;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.p_write && pfree_found_q) |=> pend_valid_q[$past(pfree_idx_q)])
    else $error("dtt_datapath: new pending entry not marked valid");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    x_store |=> exp_valid_q[$past(xfree_idx_q)])
    else $error("dtt_datapath: timed-out entry not marked valid");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.x_eval && x_match && is_check) |=> (!exp_valid_q[$past(xidx_q)] && tout_q))
    else $error("dtt_datapath: checked descriptor not removed");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.p_eval && is_expire && p_hit) |=> !pend_valid_q[$past(pidx_q)])
    else $error("dtt_datapath: expired pending entry still valid");

endmodule

`default_nettype wire
